// ----- hdl/rtp_header_parser_unit_macros.svh -----
// ----------------------------------------------------------------------------
// RTP header parser assertion macros
// Shared concurrent assertion forms for the parser blocks.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_UNIT_MACROS_SVH
`define RTP_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtp header parser assertion failed");

// next-cycle implication
`define RHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtp header parser assertion failed");

`else

`define RHP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RHP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP header parser package
// Request and response types, status codes and shared constants.
// ----------------------------------------------------------------------------
package rhp_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 65535;
   localparam int POS_W                = 16;
   localparam int FIXED_HDR_BYTES      = 12;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_BAD_VER    = 3'd2,
      STATUS_SRC_MISS   = 3'd3,
      STATUS_NO_PAYLOAD = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD    = 1'b0,
      KIND_DESCRIPTOR = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [6:0]  payload_type;
      logic        marker;
      logic [3:0]  csrc_count;
      logic [15:0] sequence_res;
      logic [31:0] timestamp;
      logic [31:0] source_id;
   } rsp_type;

   typedef struct packed {
      logic push_payload;
      logic push_desc;
   } push_type;

endpackage

// ----- hdl/rhp_parse.sv -----
// ----------------------------------------------------------------------------
// RTP header parser step logic
// Holds packet state, captures header fields and builds the responses.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_unit_macros.svh"

module rhp_parse import rhp_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        accept,
   input  req_type     req,
   output push_type    push,
   output rsp_type     payload_rsp,
   output rsp_type     desc_rsp
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

   logic [31:0]      filter_ff;
   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [7:0]       fhb_ff,  fhb_in;
   logic [7:0]       shb_ff,  shb_in;
   logic [15:0]      seq_ff,  seq_in;
   logic [31:0]      ts_ff,   ts_in;
   logic [31:0]      src_ff,  src_in;

   logic [7:0]       fhb_n, shb_n;
   logic [15:0]      seq_n;
   logic [31:0]      ts_n, src_n;
   logic [POS_W-1:0] count;
   logic [6:0]       hdr;
   logic             ver_ok, src_ok, fwd;
   status_type       status;

   always_comb begin
      fhb_n = fhb_ff;
      shb_n = shb_ff;
      seq_n = seq_ff;
      ts_n  = ts_ff;
      src_n = src_ff;
      if (pos_ff == POS_W'(0)) begin
         fhb_n = req.data_byte;
      end else if (pos_ff == POS_W'(1)) begin
         shb_n = req.data_byte;
      end else if (pos_ff < POS_W'(4)) begin
         seq_n = {seq_ff[7:0], req.data_byte};
      end else if (pos_ff < POS_W'(8)) begin
         ts_n = {ts_ff[23:0], req.data_byte};
      end else if (pos_ff < POS_W'(FIXED_HDR_BYTES)) begin
         src_n = {src_ff[23:0], req.data_byte};
      end

      count  = (pos_ff < MAX_POS) ? pos_ff + POS_W'(1) : MAX_POS;
      hdr    = 7'(FIXED_HDR_BYTES) + {1'b0, fhb_n[3:0], 2'b00};
      ver_ok = (fhb_n[7:6] == 2'b10);
      src_ok = (filter_ff == 32'd0) || (src_n == filter_ff);
      fwd    = (pos_ff >= POS_W'(FIXED_HDR_BYTES)) && (pos_ff >= POS_W'(hdr))
               && ver_ok && src_ok;

      priority if (count < POS_W'(FIXED_HDR_BYTES)) begin
         status = STATUS_SHORT;
      end else if (!ver_ok) begin
         status = STATUS_BAD_VER;
      end else if (!src_ok) begin
         status = STATUS_SRC_MISS;
      end else if (count <= POS_W'(hdr)) begin
         status = STATUS_NO_PAYLOAD;
      end else begin
         status = STATUS_OK;
      end

      payload_rsp              = '0;
      payload_rsp.kind         = KIND_PAYLOAD;
      payload_rsp.payload_byte = req.data_byte;

      desc_rsp        = '0;
      desc_rsp.kind   = KIND_DESCRIPTOR;
      desc_rsp.status = status;
      if (status != STATUS_SHORT) begin
         desc_rsp.payload_type = shb_n[6:0];
         desc_rsp.marker       = shb_n[7];
         desc_rsp.csrc_count   = fhb_n[3:0];
         desc_rsp.sequence_res = seq_n;
         desc_rsp.timestamp    = ts_n;
         desc_rsp.source_id    = src_n;
      end

      push.push_payload = accept && fwd;
      push.push_desc    = accept && req.last_byte;

      pos_in = pos_ff;
      fhb_in = fhb_ff;
      shb_in = shb_ff;
      seq_in = seq_ff;
      ts_in  = ts_ff;
      src_in = src_ff;
      if (accept) begin
         if (req.last_byte) begin
            pos_in = '0;
            fhb_in = '0;
            shb_in = '0;
            seq_in = '0;
            ts_in  = '0;
            src_in = '0;
         end else begin
            pos_in = count;
            fhb_in = fhb_n;
            shb_in = shb_n;
            seq_in = seq_n;
            ts_in  = ts_n;
            src_in = src_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
         pos_ff    <= '0;
         fhb_ff    <= '0;
         shb_ff    <= '0;
         seq_ff    <= '0;
         ts_ff     <= '0;
         src_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            filter_ff <= csr_write_data;
         end
         pos_ff <= pos_in;
         fhb_ff <= fhb_in;
         shb_ff <= shb_in;
         seq_ff <= seq_in;
         ts_ff  <= ts_in;
         src_ff <= src_in;
      end
   end

   `RHP_ASSERT_NEXT(a_clear_on_last, clock, reset, accept && req.last_byte, pos_ff == '0)
   `RHP_ASSERT_IMPL(a_no_fwd_in_hdr, clock, reset, push.push_payload, pos_ff >= POS_W'(FIXED_HDR_BYTES))

endmodule

// ----- hdl/rhp_resp_queue.sv -----
// ----------------------------------------------------------------------------
// RTP header parser response queue
// Two-entry response buffer; takes up to two responses per request.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_unit_macros.svh"

module rhp_resp_queue import rhp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  payload_rsp,
   input  rsp_type  desc_rsp,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   output logic     req_ready
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;
   logic [1:0] cnt_pop, npush;
   rsp_type    first_push;

   always_comb begin
      pop        = rsp_valid && rsp_ready;
      cnt_pop    = count_ff - {1'b0, pop};
      npush      = {1'b0, push.push_payload} + {1'b0, push.push_desc};
      first_push = push.push_payload ? payload_rsp : desc_rsp;

      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      unique case (cnt_pop)
         2'd0: begin
            slot0_in = first_push;
            slot1_in = desc_rsp;
         end
         2'd1: begin
            slot0_in = pop ? slot1_ff : slot0_ff;
            slot1_in = first_push;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
      count_in = cnt_pop + npush;
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `RHP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2)
   `RHP_ASSERT_IMPL(a_no_push_full, clock, reset, push.push_payload || push.push_desc, cnt_pop == 2'd0 || npush == 2'd1)

endmodule

// ----- hdl/rtp_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// RTP header parser unit
// Takes one packet byte per request and returns payload bytes and an
// end-of-packet descriptor with the fixed RTP header fields and a status.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle while responses are taken at once. A
// request that yields both a payload byte and the descriptor (the final byte
// of a packet with accepted payload) fills both entries of the two-entry
// response queue, so the next request waits while the second one drains.
// The first response of a request appears in the cycle after its request.
// The source filter is read at every byte; write it only between packets.
// ----------------------------------------------------------------------------
module rtp_header_parser_unit import rhp_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   logic     accept;
   push_type push;
   rsp_type  payload_rsp;
   rsp_type  desc_rsp;

   assign accept = req_valid && req_ready;

   rhp_parse #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .accept        (accept),
      .req           (req_data),
      .push          (push),
      .payload_rsp   (payload_rsp),
      .desc_rsp      (desc_rsp)
   );

   rhp_resp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .payload_rsp(payload_rsp),
      .desc_rsp   (desc_rsp),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .req_ready  (req_ready)
   );

endmodule
